// ----- src/rau_pkg.sv -----
`default_nettype none
package rau_pkg;
    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
        OP_CMP = 3'd4, OP_NORM = 3'd5, OP_RECIP = 3'd6, OP_ABS = 3'd7
    } t_opcode;
    localparam int WIDE_BITS = 128;
    typedef logic [WIDE_BITS-1:0] t_wide;
endpackage
`default_nettype wire

// ----- src/rational_arithmetic_unit.sv -----
`default_nettype none
// Fraction arithmetic unit: add, sub, mul, div, compare, normalise, reciprocal and
// absolute value on fractions of WORD_BITS-bit signed parts, results reduced by a
// binary gcd and two restoring divisions, all on 128-bit shift/subtract logic. One
// word is processed at a time. Each 64x64 product is formed one 32x32 partial product
// a cycle; add, sub, mul and div form three products, then a binary gcd of shift and
// subtract steps plus shift-back steps, then two 128-bit restoring divisions. A
// normalise, reciprocal or absolute value skips the products. tready is low while a
// word is in progress; the result is held in an output register until taken.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode[2:0], a_num[66:3], a_den[130:67], b_num[194:131], b_den[258:195]
    input  wire logic [263:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // res_num[63:0], res_den[126:64], is_less, is_equal, div_error, overflow
    output logic [135:0]      m_axis_tdata
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_SUM, S_G0, S_GA, S_GB, S_GSUB, S_GSHL,
        S_DIV, S_FIN, S_OUT
    } t_state;

    t_state      r_state;
    t_opcode     r_op;
    logic        r_sna, r_sda, r_snb, r_sdb;
    logic [63:0] r_man, r_mad, r_mbn, r_mbd;
    t_wide       r_t1, r_t2, r_n, r_d, r_ga, r_gb, r_g, r_q, r_r;
    logic        r_neg, r_second;
    logic [6:0]  r_k, r_i;
    logic [135:0] r_out;

    logic        w_mstart, w_mdone;
    logic [63:0] w_ma, w_mb;
    t_wide       w_prod;

    rau_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(w_ma), .i_b(w_mb), .o_prod(w_prod), .o_done(w_mdone)
    );

    // operand decode: sign extension of the low WORD_BITS bits
    function automatic logic [63:0] sx(input logic [63:0] v);
        logic [63:0] r;
        r = v;
        for (int j = WORD_BITS; j < 64; j++) r[j] = v[WORD_BITS-1];
        return r;
    endfunction

    logic [63:0] w_an, w_ad, w_bn, w_bd;
    assign w_an = sx(s_axis_tdata[66:3]);
    assign w_ad = sx(s_axis_tdata[130:67]);
    assign w_bn = sx(s_axis_tdata[194:131]);
    assign w_bd = sx(s_axis_tdata[258:195]);

    // multiplier operand select per product step
    always_comb begin
        w_ma = r_man; w_mb = r_mbd;
        case (r_state)
            S_M1: begin
                if (r_op == OP_MUL) begin w_ma = r_man; w_mb = r_mbn; end
                else if (r_op == OP_DIV) begin w_ma = r_man; w_mb = r_mbd; end
                else begin w_ma = r_man; w_mb = r_mbd; end
            end
            S_M2: begin
                if (r_op == OP_MUL) begin w_ma = r_mad; w_mb = r_mbd; end
                else if (r_op == OP_DIV) begin w_ma = r_mad; w_mb = r_mbn; end
                else begin w_ma = r_mbn; w_mb = r_mad; end
            end
            default: begin w_ma = r_mad; w_mb = r_mbd; end
        endcase
    end

    logic w_accept, w_sending;
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_sending = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;
    assign m_axis_tdata  = r_out;

    // signed-magnitude sum terms for add and sub
    logic  w_s1, w_s2;
    assign w_s1 = r_sna ^ r_sdb;
    assign w_s2 = (r_snb ^ r_sda) ^ (r_op == OP_SUB);

    // restoring division step: shift in the next dividend bit and compare with the divisor
    t_wide w_rs, w_dn;
    logic  w_ge;
    assign w_dn = r_second ? r_d : r_n;
    assign w_rs = {r_r[126:0], w_dn[r_i]};
    assign w_ge = (r_r[127] == 1'b0) && (w_rs >= r_g);

    // finishing: fit check and field packing
    logic [63:0] w_lim, w_nl, w_num;
    logic        w_negz, w_fit;
    assign w_lim  = 64'd1 << (WORD_BITS - 1);
    assign w_negz = r_neg && (r_t1 != '0);
    assign w_fit  = (r_t1[127:64] == '0) && (w_negz ? r_t1[63:0] <= w_lim
                    : r_t1[63:0] < w_lim) && (r_q[127:64] == '0) && (r_q[63:0] < w_lim);
    assign w_nl   = w_negz ? (64'd0 - r_t1[63:0]) : r_t1[63:0];
    assign w_num  = sx(w_nl);

    logic  w_cmp_lt, w_cmp_eq, w_pa, w_pb;
    logic  w_cl;
    assign w_pa = w_s1 && (r_t1 != '0);
    assign w_pb = (r_snb ^ r_sda) && (r_t2 != '0);
    always_comb begin
        if (w_pa != w_pb) w_cl = w_pa;
        else if (w_pa) w_cl = r_t1 > r_t2;
        else w_cl = r_t1 < r_t2;
    end
    assign w_cmp_eq = (w_pa == w_pb) && (r_t1 == r_t2);
    assign w_cmp_lt = (r_sda != r_sdb) ? (!w_cl && !w_cmp_eq) : w_cl;

    assign w_mstart = (r_state == S_M1 || r_state == S_M2 || r_state == S_M3) && !r_second;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            m_axis_tvalid <= 1'b0;
            r_second      <= 1'b0;
        end else begin
            if (w_sending) m_axis_tvalid <= 1'b0;
            case (r_state)
                S_IDLE: if (w_accept) begin
                    r_op  <= t_opcode'(s_axis_tdata[2:0]);
                    r_sna <= w_an[63]; r_sda <= w_ad[63];
                    r_snb <= w_bn[63]; r_sdb <= w_bd[63];
                    r_man <= w_an[63] ? 64'd0 - w_an : w_an;
                    r_mad <= w_ad[63] ? 64'd0 - w_ad : w_ad;
                    r_mbn <= w_bn[63] ? 64'd0 - w_bn : w_bn;
                    r_mbd <= w_bd[63] ? 64'd0 - w_bd : w_bd;
                    r_second <= 1'b0;
                    r_state  <= S_M1;
                end
                S_M1: begin
                    if ((r_mad == '0)
                        || ((r_op == OP_ADD || r_op == OP_SUB || r_op == OP_MUL
                             || r_op == OP_DIV || r_op == OP_CMP) && r_mbd == '0)
                        || (r_op == OP_DIV && r_mbn == '0)
                        || (r_op == OP_RECIP && r_man == '0)) begin
                        r_out <= {5'd0, 1'b0, 1'b1, 1'b0, 1'b0, 63'd1, 64'd0};
                        r_state <= S_OUT;
                    end else if (r_op == OP_NORM || r_op == OP_ABS) begin
                        r_n <= {64'd0, r_man}; r_d <= {64'd0, r_mad};
                        r_neg <= (r_op == OP_NORM) && (r_sna ^ r_sda);
                        r_state <= S_G0;
                    end else if (r_op == OP_RECIP) begin
                        r_n <= {64'd0, r_mad}; r_d <= {64'd0, r_man};
                        r_neg <= r_sna ^ r_sda;
                        r_state <= S_G0;
                    end else if (!r_second) r_second <= 1'b1;
                    else if (w_mdone) begin
                        r_t1 <= w_prod; r_second <= 1'b0; r_state <= S_M2;
                    end
                end
                S_M2: begin
                    if (!r_second) r_second <= 1'b1;
                    else if (w_mdone) begin
                        r_t2 <= w_prod; r_second <= 1'b0;
                        if (r_op == OP_CMP) r_state <= S_SUM;
                        else r_state <= S_M3;
                    end
                end
                S_M3: begin
                    if (!r_second) r_second <= 1'b1;
                    else if (w_mdone) begin
                        r_d <= w_prod; r_second <= 1'b0; r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_op == OP_CMP) begin
                        r_out <= {5'd0, 1'b0, 1'b0, w_cmp_eq, w_cmp_lt, 63'd1, 64'd0};
                        r_state <= S_OUT;
                    end else if (r_op == OP_MUL || r_op == OP_DIV) begin
                        r_n <= r_t1;
                        r_d <= r_t2;
                        r_neg <= (r_sna ^ r_sda) ^ (r_snb ^ r_sdb);
                        r_state <= S_G0;
                    end else begin
                        if (w_s1 == w_s2) begin r_n <= r_t1 + r_t2; r_neg <= w_s1 ^ r_sda ^ r_sdb; end
                        else if (r_t1 >= r_t2) begin
                            r_n <= r_t1 - r_t2; r_neg <= w_s1 ^ r_sda ^ r_sdb;
                        end else begin
                            r_n <= r_t2 - r_t1; r_neg <= w_s2 ^ r_sda ^ r_sdb;
                        end
                        r_state <= S_G0;
                    end
                end
                S_G0: begin
                    r_k <= '0;
                    if (r_n == '0) begin
                        r_g <= r_d; r_i <= 7'd127; r_r <= '0; r_q <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_ga <= r_n; r_gb <= r_d; r_state <= S_GA;
                    end
                end
                // strip common and then own factors of two
                S_GA: begin
                    if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1; r_gb <= r_gb >> 1; r_k <= r_k + 7'd1;
                    end else if (!r_ga[0]) r_ga <= r_ga >> 1;
                    else r_state <= S_GB;
                end
                S_GB: begin
                    if (!r_gb[0]) r_gb <= r_gb >> 1;
                    else r_state <= S_GSUB;
                end
                S_GSUB: begin
                    if (r_ga > r_gb) begin
                        r_ga <= r_gb; r_gb <= r_ga - r_gb;
                        if (r_ga - r_gb == '0) r_state <= S_GSHL; else r_state <= S_GB;
                    end else begin
                        r_gb <= r_gb - r_ga;
                        if (r_gb - r_ga == '0) r_state <= S_GSHL; else r_state <= S_GB;
                    end
                end
                S_GSHL: begin
                    if (r_k != '0) begin r_ga <= r_ga << 1; r_k <= r_k - 7'd1; end
                    else begin
                        r_g <= r_ga; r_i <= 7'd127; r_r <= '0; r_q <= '0;
                        r_second <= 1'b0; r_state <= S_DIV;
                    end
                end
                // restoring division, one quotient bit a cycle
                S_DIV: begin
                    if (r_i != '0) begin
                        r_r <= w_ge ? (w_rs - r_g) : w_rs;
                        r_q <= {r_q[126:0], w_ge};
                        r_i <= r_i - 7'd1;
                    end else if (!r_second) begin
                        r_t1 <= {r_q[126:0], w_ge};
                        r_second <= 1'b1; r_i <= 7'd127; r_r <= '0; r_q <= '0;
                    end else begin
                        r_q <= {r_q[126:0], w_ge};
                        r_second <= 1'b0; r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_out <= {5'd0, !w_fit, 1'b0, 1'b0, 1'b0,
                              r_q[62:0] & (w_lim[62:0] - 63'd1), w_num};
                    r_state <= S_OUT;
                end
                S_OUT: if (!m_axis_tvalid) begin
                    m_axis_tvalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // no new word taken while a result waits
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
    // error results are always 0/1
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[129]) |-> (m_axis_tdata[63:0] == '0
        && m_axis_tdata[126:64] == 63'd1)) else $error("error result not 0/1");
    // denominator never zero without overflow
    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[130]) |-> (m_axis_tdata[126:64] != '0))
        else $error("zero denominator");
`endif
endmodule
`default_nettype wire

// ----- src/rau_mul.sv -----
`default_nettype none
// 64x64 unsigned multiplier, one 32x32 partial product per cycle
module rau_mul (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output rau_pkg::t_wide    o_prod,
    output logic              o_done
);
    import rau_pkg::*;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic [63:0] r_a, r_b;
    t_wide       r_acc;
    logic [31:0] w_x, w_y;
    logic [63:0] w_pp;

    // pick the partial product for this cycle
    assign w_x  = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign w_y  = r_cnt[1] ? r_b[63:32] : r_b[31:0];
    assign w_pp = w_x * w_y;

    // accumulate shifted partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= r_acc + ({64'd0, w_pp} << (32 * (r_cnt[0] + r_cnt[1])));
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_prod = r_acc;
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import rau_pkg::*;

    typedef struct packed {
        logic [63:0] num;
        logic [62:0] den;
        logic        lt;
        logic        eq;
        logic        dz;
        logic        ovf;
    } t_frac_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [263:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;

    t_frac_res    expected_q[$];
    int           n_errors = 0;
    longint       cycle_cnt = 0;
    bit           rx_steady = 1'b0;
    int           rx_hold = 0;

    rational_arithmetic_unit #(.WORD_BITS(64)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // run limit: time for every word plus stalls, taken several times over
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 4_000_000) begin
            $display("rational_arithmetic_unit: mismatch");
            $finish;
        end
    end

    // 128-bit helpers
    function automatic logic [127:0] gcd_wide(logic [127:0] x, logic [127:0] y);
        logic [127:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // reduce a signed fraction into a result word
    function automatic t_frac_res reduce_frac(bit neg, logic [127:0] n, logic [127:0] d);
        t_frac_res r;
        logic [127:0] g;
        bit fits;
        g = gcd_wide(n, d);
        n = n / g;
        d = d / g;
        if (n == 0) neg = 1'b0;
        fits = n[127:64] == 0 && (neg ? n[63:0] <= 64'h8000_0000_0000_0000
                                      : n[63:0] < 64'h8000_0000_0000_0000)
               && d[127:63] == 0;
        r = '0;
        r.num = neg ? -n[63:0] : n[63:0];
        r.den = d[62:0];
        r.ovf = !fits;
        return r;
    endfunction

    function automatic logic [63:0] mag64(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // predicted result of one operation
    function automatic t_frac_res frac_op(t_opcode op, logic [63:0] an, logic [63:0] ad,
                                         logic [63:0] bn, logic [63:0] bd);
        t_frac_res r;
        logic [127:0] man, mad, mbn, mbd, t1, t2, n;
        bit sna, sda, snb, sdb, s1, s2, s, la, lb;
        int c;
        sna = an[63]; sda = ad[63]; snb = bn[63]; sdb = bd[63];
        man = {64'd0, mag64(an)}; mad = {64'd0, mag64(ad)};
        mbn = {64'd0, mag64(bn)}; mbd = {64'd0, mag64(bd)};
        r = '0;
        r.den = 63'd1;
        if (mad == 0 || (op <= OP_CMP && mbd == 0) || (op == OP_DIV && mbn == 0)
                || (op == OP_RECIP && man == 0)) begin
            r.dz = 1'b1;
            return r;
        end
        case (op)
            OP_ADD, OP_SUB: begin
                s1 = sna != sdb;
                s2 = (snb != sda) != (op == OP_SUB);
                t1 = man * mbd;
                t2 = mbn * mad;
                if (s1 == s2) begin
                    n = t1 + t2; s = s1;
                end else if (t1 >= t2) begin
                    n = t1 - t2; s = s1;
                end else begin
                    n = t2 - t1; s = s2;
                end
                r = reduce_frac(s != (sda != sdb), n, mad * mbd);
            end
            OP_MUL: r = reduce_frac((sna != sda) != (snb != sdb), man * mbn, mad * mbd);
            OP_DIV: r = reduce_frac((sna != sda) != (snb != sdb), man * mbd, mad * mbn);
            OP_CMP: begin
                t1 = man * mbd;
                t2 = mbn * mad;
                la = (t1 != 0) && (sna != sdb);
                lb = (t2 != 0) && (snb != sda);
                if (la != lb) c = la ? -1 : 1;
                else c = (t1 == t2) ? 0 : ((t1 < t2) != la) ? -1 : 1;
                if (sda != sdb) c = -c;
                r.lt = c < 0;
                r.eq = c == 0;
            end
            OP_NORM:  r = reduce_frac(sna != sda, man, mad);
            OP_RECIP: r = reduce_frac(sna != sda, mad, man);
            default:  r = reduce_frac(1'b0, man, mad);
        endcase
        return r;
    endfunction

    function automatic bit idle_now();
        return !rx_steady && $urandom_range(99) < 15;
    endfunction

    // send one word and queue its prediction
    task automatic send_word(t_opcode op, logic [63:0] an, logic [63:0] ad,
                             logic [63:0] bn, logic [63:0] bd);
        @(negedge i_clk);
        while (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, bd, bn, ad, an, op};
        expected_q.push_back(frac_op(op, an, ad, bn, bd));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [63:0] rnd_part();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = $signed(v[7:0]);
            1: v = $signed(v[19:0]);
            2: v = $signed(v[35:0]);
            3: v = {v[63], 63'h7fff_ffff_ffff_ffff} ^ {1'b0, 63'(v[0])};
            default: ;
        endcase
        return v;
    endfunction

    // receiver side: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !idle_now();
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("error @%0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_frac_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.num = m_axis_tdata[63:0];
            got.den = m_axis_tdata[126:64];
            got.lt  = m_axis_tdata[127];
            got.eq  = m_axis_tdata[128];
            got.dz  = m_axis_tdata[129];
            got.ovf = m_axis_tdata[130];
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", got.num, 0);
            end else begin
                want = expected_q.pop_front();
                if (got.num !== want.num) report_mismatch("res_num", got.num, want.num);
                if (got.den !== want.den) report_mismatch("res_den", got.den, want.den);
                if (got.lt !== want.lt) report_mismatch("is_less", got.lt, want.lt);
                if (got.eq !== want.eq) report_mismatch("is_equal", got.eq, want.eq);
                if (got.dz !== want.dz) report_mismatch("div_error", got.dz, want.dz);
                if (got.ovf !== want.ovf) report_mismatch("overflow", got.ovf, want.ovf);
            end
        end
    end

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;

    task automatic test_directed();
        t_opcode op;
        for (int i = 0; i < 8; i++) begin
            op = t_opcode'(i);
            send_word(op, 64'd6, -64'sd4, 64'd3, 64'd9);
        end
        send_word(OP_ADD, MAX64, 64'd1, MAX64, 64'd1);
        send_word(OP_MUL, MIN64, 64'd1, MIN64, 64'd1);
        send_word(OP_NORM, MIN64, -64'sd1, 64'd0, 64'd0);
        send_word(OP_ABS, MIN64, 64'd1, 64'd0, 64'd0);
        send_word(OP_RECIP, 64'd1, MIN64, 64'd0, 64'd0);
        send_word(OP_ADD, 64'd1, 64'd0, 64'd1, 64'd1);
        send_word(OP_SUB, 64'd1, 64'd1, 64'd1, 64'd0);
        send_word(OP_DIV, 64'd1, 64'd2, 64'd0, 64'd3);
        send_word(OP_RECIP, 64'd0, 64'd5, 64'd0, 64'd0);
        send_word(OP_CMP, 64'd1, -64'sd2, -64'sd1, 64'd2);
        send_word(OP_CMP, MIN64, 64'd1, MAX64, -64'sd1);
        send_word(OP_CMP, 64'd0, -64'sd3, 64'd0, 64'd7);
        send_word(OP_SUB, 64'd5, 64'd7, 64'd5, 64'd7);
        send_word(OP_DIV, MAX64, MIN64, MIN64, MAX64);
        send_word(OP_NORM, -64'sd1, -64'sd1, 64'hffff_ffff_ffff_ffff, MAX64);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_word(t_opcode'($urandom_range(7)), rnd_part(), rnd_part(),
                      rnd_part(), rnd_part());
    endtask

    // receiver holds off while sender keeps offering words
    task automatic test_backpressure();
        @(negedge i_clk);
        rx_hold <= 3000;
        test_random(10);
    endtask

    task automatic test_no_idle();
        rx_steady = 1'b1;
        test_random(150);
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(500);
        test_no_idle();
        test_random(520);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("rational_arithmetic_unit: match");
        else
            $display("rational_arithmetic_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
